FILE: design/rv32ex_pkg.sv
// ----------------------------------------------------------------------------
// RV32I execute unit package
// Shared widths, operation codes and structs of the execute unit.
// ----------------------------------------------------------------------------
package rv32ex_pkg;

  localparam int unsigned MemAddrBitsDef = 16;
  localparam int unsigned Xlen           = 32;
  localparam int unsigned NumRegs        = 32;
  localparam int unsigned RegIdxW        = 5;
  localparam int unsigned OpW            = 6;
  localparam int unsigned ImmW           = 21;
  localparam int unsigned ShamtW         = 5;
  localparam logic [31:0] JalrMask       = 32'hFFFF_FFFE;

  typedef enum logic [OpW-1:0] {
    OP_LUI   = 6'd0,  OP_AUIPC = 6'd1,  OP_JAL   = 6'd2,  OP_JALR  = 6'd3,
    OP_BEQ   = 6'd4,  OP_BNE   = 6'd5,  OP_BLT   = 6'd6,  OP_BGE   = 6'd7,
    OP_BLTU  = 6'd8,  OP_BGEU  = 6'd9,  OP_LB    = 6'd10, OP_LH    = 6'd11,
    OP_LW    = 6'd12, OP_LBU   = 6'd13, OP_LHU   = 6'd14, OP_SB    = 6'd15,
    OP_SH    = 6'd16, OP_SW    = 6'd17, OP_ADDI  = 6'd18, OP_SLTI  = 6'd19,
    OP_SLTIU = 6'd20, OP_XORI  = 6'd21, OP_ORI   = 6'd22, OP_ANDI  = 6'd23,
    OP_SLLI  = 6'd24, OP_SRLI  = 6'd25, OP_SRAI  = 6'd26, OP_ADD   = 6'd27,
    OP_SUB   = 6'd28, OP_SLL   = 6'd29, OP_SLT   = 6'd30, OP_SLTU  = 6'd31,
    OP_XOR   = 6'd32, OP_SRL   = 6'd33, OP_SRA   = 6'd34, OP_OR    = 6'd35,
    OP_AND   = 6'd36
  } op_e;

  typedef enum logic [1:0] {
    SZ_BYTE = 2'd0,
    SZ_HALF = 2'd1,
    SZ_WORD = 2'd2
  } size_e;

  // Outcome of the execute stage for one item
  typedef struct packed {
    logic [Xlen-1:0]    next_pc;
    logic               reg_wr;
    logic [RegIdxW-1:0] idx;
    logic [Xlen-1:0]    value;
    logic               load;
    logic               store;
    size_e              size;
    logic [Xlen-1:0]    addr;
  } ex_res_t;

  // Data memory access request
  typedef struct packed {
    logic            en;
    logic            wr;
    size_e           size;
    logic [Xlen-1:0] addr;
    logic [Xlen-1:0] data;
  } dmem_req_t;

endpackage

FILE: design/rv32ex_if.sv
// ----------------------------------------------------------------------------
// RV32I execute unit channels
// Valid/ready channels for decoded instructions and for results.
// ----------------------------------------------------------------------------
interface rv32ex_in_if;
  logic                              valid;
  logic                              ready;
  logic [rv32ex_pkg::OpW-1:0]        opcode;
  logic [rv32ex_pkg::RegIdxW-1:0]    dest_index;
  logic [rv32ex_pkg::RegIdxW-1:0]    source1_index;
  logic [rv32ex_pkg::RegIdxW-1:0]    source2_index;
  logic signed [rv32ex_pkg::ImmW-1:0] immediate;

  modport source (
    output valid, opcode, dest_index, source1_index, source2_index, immediate,
    input  ready
  );
  modport sink (
    input  valid, opcode, dest_index, source1_index, source2_index, immediate,
    output ready
  );
endinterface

interface rv32ex_out_if;
  logic                           valid;
  logic                           ready;
  logic [rv32ex_pkg::Xlen-1:0]    next_pc;
  logic                           reg_written;
  logic [rv32ex_pkg::RegIdxW-1:0] written_index;
  logic [rv32ex_pkg::Xlen-1:0]    written_value;
  logic                           mem_stored;
  logic [rv32ex_pkg::Xlen-1:0]    mem_address;

  modport source (
    output valid, next_pc, reg_written, written_index, written_value, mem_stored,
           mem_address,
    input  ready
  );
  modport sink (
    input  valid, next_pc, reg_written, written_index, written_value, mem_stored,
           mem_address,
    output ready
  );
endinterface

FILE: design/rv32ex_alu.sv
// ----------------------------------------------------------------------------
// RV32I execute ALU
// Operand selection, arithmetic, compares, shifts and next-pc for one item.
// ----------------------------------------------------------------------------
module rv32ex_alu (
  input  rv32ex_pkg::op_e                     op_i,
  input  logic [rv32ex_pkg::RegIdxW-1:0]      rd_i,
  input  logic [rv32ex_pkg::Xlen-1:0]         a_i,
  input  logic [rv32ex_pkg::Xlen-1:0]         b_i,
  input  logic signed [rv32ex_pkg::ImmW-1:0]  imm_i,
  input  logic [rv32ex_pkg::Xlen-1:0]         pc_i,
  output rv32ex_pkg::ex_res_t                 res_o
);

  logic [31:0] imm32, upper, opb, sum, diff, pc4, br_tgt;
  logic [31:0] sll_r, srl_r, sra_r, val;
  logic [4:0]  shamt;
  logic        use_b, eq, lt_s, lt_u, wr, br, ld, st;
  rv32ex_pkg::size_e size;
  logic [31:0] npc, maddr;

  assign imm32  = {{(32 - rv32ex_pkg::ImmW){imm_i[rv32ex_pkg::ImmW-1]}}, imm_i};
  assign upper  = {imm_i[19:0], 12'h000};
  assign use_b  = op_i inside {[rv32ex_pkg::OP_BEQ:rv32ex_pkg::OP_BGEU],
                               [rv32ex_pkg::OP_ADD:rv32ex_pkg::OP_AND]};
  assign opb    = use_b ? b_i : imm32;
  assign sum    = a_i + opb;
  assign diff   = a_i - b_i;
  assign pc4    = pc_i + 32'd4;
  assign br_tgt = pc_i + imm32;
  assign eq     = (a_i == b_i);
  assign lt_s   = ($signed(a_i) < $signed(opb));
  assign lt_u   = (a_i < opb);
  assign shamt  = opb[rv32ex_pkg::ShamtW-1:0];
  assign sll_r  = a_i << shamt;
  assign srl_r  = a_i >> shamt;
  assign sra_r  = 32'($signed(a_i) >>> shamt);

  always_comb begin
    val   = '0;
    wr    = 1'b0;
    br    = 1'b0;
    ld    = 1'b0;
    st    = 1'b0;
    size  = rv32ex_pkg::SZ_WORD;
    npc   = pc4;
    maddr = '0;
    case (op_i)
      rv32ex_pkg::OP_LUI:   begin val = upper;        wr = 1'b1; end
      rv32ex_pkg::OP_AUIPC: begin val = upper + pc_i; wr = 1'b1; end
      rv32ex_pkg::OP_JAL:   begin val = pc4; npc = br_tgt; wr = 1'b1; end
      rv32ex_pkg::OP_JALR:  begin
        val = pc4;
        npc = (a_i + imm32) & rv32ex_pkg::JalrMask;
        wr  = 1'b1;
      end
      rv32ex_pkg::OP_BEQ:   br = eq;
      rv32ex_pkg::OP_BNE:   br = !eq;
      rv32ex_pkg::OP_BLT:   br = lt_s;
      rv32ex_pkg::OP_BGE:   br = !lt_s;
      rv32ex_pkg::OP_BLTU:  br = lt_u;
      rv32ex_pkg::OP_BGEU:  br = !lt_u;
      rv32ex_pkg::OP_LB, rv32ex_pkg::OP_LBU: begin
        ld = 1'b1; wr = 1'b1; size = rv32ex_pkg::SZ_BYTE; maddr = sum;
      end
      rv32ex_pkg::OP_LH, rv32ex_pkg::OP_LHU: begin
        ld = 1'b1; wr = 1'b1; size = rv32ex_pkg::SZ_HALF; maddr = sum;
      end
      rv32ex_pkg::OP_LW:    begin ld = 1'b1; wr = 1'b1; maddr = sum; end
      rv32ex_pkg::OP_SB:    begin st = 1'b1; size = rv32ex_pkg::SZ_BYTE; maddr = sum; end
      rv32ex_pkg::OP_SH:    begin st = 1'b1; size = rv32ex_pkg::SZ_HALF; maddr = sum; end
      rv32ex_pkg::OP_SW:    begin st = 1'b1; maddr = sum; end
      rv32ex_pkg::OP_ADDI, rv32ex_pkg::OP_ADD: begin val = sum; wr = 1'b1; end
      rv32ex_pkg::OP_SUB:   begin val = diff; wr = 1'b1; end
      rv32ex_pkg::OP_SLTI, rv32ex_pkg::OP_SLT: begin val = {31'd0, lt_s}; wr = 1'b1; end
      rv32ex_pkg::OP_SLTIU, rv32ex_pkg::OP_SLTU: begin val = {31'd0, lt_u}; wr = 1'b1; end
      rv32ex_pkg::OP_XORI, rv32ex_pkg::OP_XOR: begin val = a_i ^ opb; wr = 1'b1; end
      rv32ex_pkg::OP_ORI, rv32ex_pkg::OP_OR:   begin val = a_i | opb; wr = 1'b1; end
      rv32ex_pkg::OP_ANDI, rv32ex_pkg::OP_AND: begin val = a_i & opb; wr = 1'b1; end
      rv32ex_pkg::OP_SLLI, rv32ex_pkg::OP_SLL: begin val = sll_r; wr = 1'b1; end
      rv32ex_pkg::OP_SRLI, rv32ex_pkg::OP_SRL: begin val = srl_r; wr = 1'b1; end
      rv32ex_pkg::OP_SRAI, rv32ex_pkg::OP_SRA: begin val = sra_r; wr = 1'b1; end
      default: ;
    endcase
    if (br) begin
      npc = br_tgt;
    end
  end

  // drop writes to x0
  always_comb begin
    res_o.next_pc = npc;
    res_o.reg_wr  = wr && (rd_i != '0);
    res_o.idx     = res_o.reg_wr ? rd_i : '0;
    res_o.value   = res_o.reg_wr ? val : '0;
    res_o.load    = ld;
    res_o.store   = st;
    res_o.size    = size;
    res_o.addr    = maddr;
  end

endmodule

FILE: design/rv32ex_dmem.sv
// ----------------------------------------------------------------------------
// RV32I execute data memory
// Four byte-wide banks; any access of up to four bytes, aligned or not.
// ----------------------------------------------------------------------------
module rv32ex_dmem #(
  parameter int unsigned MEM_ADDR_BITS = rv32ex_pkg::MemAddrBitsDef
) (
  input  logic                          clk_i,
  input  rv32ex_pkg::dmem_req_t         req_i,
  output logic [rv32ex_pkg::Xlen-1:0]   rdata_o
);

  localparam int unsigned RowW = MEM_ADDR_BITS - 2;
  localparam int unsigned Rows = 2 ** RowW;

  logic [1:0]      ofs;
  logic [1:0]      ofs_q;
  logic [RowW-1:0] arow;
  logic [7:0]      bank_rd_q [4];

  assign ofs  = req_i.addr[1:0];
  assign arow = req_i.addr[MEM_ADDR_BITS-1:2];

  always_ff @(posedge clk_i) begin
    if (req_i.en) begin
      ofs_q <= ofs;
    end
  end

  for (genvar k = 0; k < 4; k++) begin : g_bank
    logic [7:0]      mem_q [Rows];
    logic [1:0]      lane;
    logic [RowW-1:0] row;
    logic            be;
    logic [7:0]      wd;

    // bank k holds byte 'lane' of the access; it wraps to the next row
    assign lane = 2'(k) - ofs;
    assign row  = arow + RowW'(2'(k) < ofs);
    assign wd   = req_i.data[{lane, 3'b000} +: 8];

    always_comb begin
      case (req_i.size)
        rv32ex_pkg::SZ_BYTE: be = (lane == 2'd0);
        rv32ex_pkg::SZ_HALF: be = !lane[1];
        rv32ex_pkg::SZ_WORD: be = 1'b1;
        default:             be = 1'b0;
      endcase
    end

    always_ff @(posedge clk_i) begin
      if (req_i.en) begin
        if (req_i.wr && be) begin
          mem_q[row] <= wd;
        end
        bank_rd_q[k] <= mem_q[row];
      end
    end

    // rotate banks back into little-endian byte order
    assign rdata_o[8*k +: 8] = bank_rd_q[2'(ofs_q + 2'(k))];
  end

endmodule

FILE: design/rv32i_execute_unit.sv
// ----------------------------------------------------------------------------
// RV32I execute unit
// Executes one decoded RV32I instruction per item against its own register
// file, program counter and data memory, and reports one result per item.
// ----------------------------------------------------------------------------
// Path: an accepted item is registered in stage 1, then in stage 2, where its result is valid.
// Throughput: one item per cycle; ready drops only while both stages hold
//   items and the result side is stalled.
// Reset: clears the stage valid flags, the pc and the register valid bits
//   (all registers read zero); the data memory is not cleared.
// ----------------------------------------------------------------------------
module rv32i_execute_unit #(
  parameter int unsigned MEM_ADDR_BITS = rv32ex_pkg::MemAddrBitsDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  rv32ex_in_if.sink           in_i,
  rv32ex_out_if.source        out_o
);

  // --------------------------------------------------------------------------
  // Handshake and stage control
  // Stage 1 holds the instruction with its register operands, stage 2 the
  // finished result. Stage 1 advances whenever stage 2 is empty or leaving.
  // --------------------------------------------------------------------------
  logic s1_valid_q, s2_valid_q;
  logic in_acc, s1_adv, s2_leave;

  assign s2_leave   = s2_valid_q && out_o.ready;
  assign s1_adv     = s1_valid_q && (!s2_valid_q || out_o.ready);
  assign in_i.ready = !s1_valid_q || !s2_valid_q || out_o.ready;
  assign in_acc     = in_i.valid && in_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
    end else begin
      if (in_acc) begin
        s1_valid_q <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_q <= 1'b0;
      end
      if (s1_adv) begin
        s2_valid_q <= 1'b1;
      end else if (s2_leave) begin
        s2_valid_q <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stage 2 registers (declared early: they feed forwarding and write-back)
  // --------------------------------------------------------------------------
  logic [31:0]       s2_pc_q, s2_val_q, s2_addr_q, s2_value, ld_word;
  logic              s2_wr_q, s2_st_q, s2_ld_q;
  logic [4:0]        s2_idx_q;
  rv32ex_pkg::op_e   s2_op_q;

  // --------------------------------------------------------------------------
  // Register file: 32 x 32, two registered read ports issued on acceptance,
  // one write port at write-back. A write landing on the same edge as the
  // read is passed straight through. Valid bits make unwritten entries zero.
  // --------------------------------------------------------------------------
  logic [31:0] rf_q [rv32ex_pkg::NumRegs];
  logic [rv32ex_pkg::NumRegs-1:0] rf_vld_q;
  logic        rf_we;
  logic [31:0] rf_wdata;
  logic [4:0]  rf_widx;

  assign rf_we    = s2_leave && s2_wr_q;
  assign rf_widx  = s2_idx_q;
  assign rf_wdata = s2_value;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rf_vld_q <= '0;
    end else if (rf_we) begin
      rf_vld_q[rf_widx] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rf_we) begin
      rf_q[rf_widx] <= rf_wdata;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 1 registers
  // --------------------------------------------------------------------------
  rv32ex_pkg::op_e         s1_op_q;
  logic [4:0]              s1_rd_q, s1_rs1_q, s1_rs2_q;
  logic signed [20:0]      s1_imm_q;
  logic [31:0]             s1_a_q, s1_b_q;

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_op_q  <= rv32ex_pkg::op_e'(in_i.opcode);
      s1_rd_q  <= in_i.dest_index;
      s1_rs1_q <= in_i.source1_index;
      s1_rs2_q <= in_i.source2_index;
      s1_imm_q <= in_i.immediate;
      if (rf_we && rf_widx == in_i.source1_index) begin
        s1_a_q <= rf_wdata;
      end else begin
        s1_a_q <= rf_vld_q[in_i.source1_index] ? rf_q[in_i.source1_index] : '0;
      end
      if (rf_we && rf_widx == in_i.source2_index) begin
        s1_b_q <= rf_wdata;
      end else begin
        s1_b_q <= rf_vld_q[in_i.source2_index] ? rf_q[in_i.source2_index] : '0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Execute: forward the result still waiting in stage 2, then run the ALU.
  // The only write not yet in the register file is the one in stage 2.
  // --------------------------------------------------------------------------
  logic [31:0]         op_a, op_b, pc_q;
  rv32ex_pkg::ex_res_t ex;
  rv32ex_pkg::dmem_req_t dreq;

  assign op_a = (s2_valid_q && s2_wr_q && s2_idx_q == s1_rs1_q) ? s2_value : s1_a_q;
  assign op_b = (s2_valid_q && s2_wr_q && s2_idx_q == s1_rs2_q) ? s2_value : s1_b_q;

  rv32ex_alu u_alu (
    .op_i  (s1_op_q),
    .rd_i  (s1_rd_q),
    .a_i   (op_a),
    .b_i   (op_b),
    .imm_i (s1_imm_q),
    .pc_i  (pc_q),
    .res_o (ex)
  );

  // Advance the pc as each instruction leaves execute
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q <= '0;
    end else if (s1_adv) begin
      pc_q <= ex.next_pc;
    end
  end

  // --------------------------------------------------------------------------
  // Data memory: stores write and loads read as the item leaves execute;
  // load bytes arrive registered alongside stage 2.
  // --------------------------------------------------------------------------
  assign dreq.en   = s1_adv;
  assign dreq.wr   = ex.store;
  assign dreq.size = ex.size;
  assign dreq.addr = ex.addr;
  assign dreq.data = op_b;

  rv32ex_dmem #(
    .MEM_ADDR_BITS (MEM_ADDR_BITS)
  ) u_dmem (
    .clk_i   (clk_i),
    .req_i   (dreq),
    .rdata_o (ld_word)
  );

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      s2_pc_q   <= ex.next_pc;
      s2_wr_q   <= ex.reg_wr;
      s2_idx_q  <= ex.idx;
      s2_val_q  <= ex.value;
      s2_ld_q   <= ex.load;
      s2_st_q   <= ex.store;
      s2_addr_q <= ex.addr;
      s2_op_q   <= s1_op_q;
    end
  end

  // --------------------------------------------------------------------------
  // Load formatting: sign- or zero-extend the little-endian bytes
  // --------------------------------------------------------------------------
  logic [31:0] ld_val;

  always_comb begin
    case (s2_op_q)
      rv32ex_pkg::OP_LB:  ld_val = {{24{ld_word[7]}}, ld_word[7:0]};
      rv32ex_pkg::OP_LH:  ld_val = {{16{ld_word[15]}}, ld_word[15:0]};
      rv32ex_pkg::OP_LBU: ld_val = {24'd0, ld_word[7:0]};
      rv32ex_pkg::OP_LHU: ld_val = {16'd0, ld_word[15:0]};
      default:            ld_val = ld_word;
    endcase
  end

  assign s2_value = s2_ld_q ? (s2_wr_q ? ld_val : '0) : s2_val_q;

  // --------------------------------------------------------------------------
  // Result channel
  // --------------------------------------------------------------------------
  assign out_o.valid         = s2_valid_q;
  assign out_o.next_pc       = s2_pc_q;
  assign out_o.reg_written   = s2_wr_q;
  assign out_o.written_index = s2_idx_q;
  assign out_o.written_value = s2_value;
  assign out_o.mem_stored    = s2_st_q;
  assign out_o.mem_address   = s2_addr_q;

endmodule

FILE: tb/tb_top.sv
// ----------------------------------------------------------------------------
// RV32I execute unit testbench
// Drives decoded instructions into the execute unit and checks every retired
// result against an in-bench model of the register file, pc and data memory.
// Both channels idle and stall at random; loads only touch written bytes.
// ----------------------------------------------------------------------------
module tb_top;

  import rv32ex_pkg::*;

  localparam int unsigned AddrW    = MemAddrBitsDef;
  localparam int unsigned MemBytes = 1 << AddrW;
  localparam int unsigned HotAddrs = 24;
  localparam int unsigned RandomItems = 1150;
  localparam int unsigned DrainLimit  = 20000;
  localparam int unsigned TailCycles  = 10;

  // Opcodes outside the defined set; the unit must treat them as no-ops
  localparam logic [OpW-1:0] OpUnknownLo = 6'd37;
  localparam logic [OpW-1:0] OpUnknownHi = 6'd63;

  // Immediate extremes of the 21-bit field
  localparam logic [ImmW-1:0] ImmMax = 21'h0F_FFFF;
  localparam logic [ImmW-1:0] ImmMin = 21'h10_0000;
  localparam logic [ImmW-1:0] ImmAll = 21'h1F_FFFF;

  // One retired instruction as seen on the result channel
  typedef struct packed {
    logic [Xlen-1:0]    next_pc;
    logic               reg_written;
    logic [RegIdxW-1:0] written_index;
    logic [Xlen-1:0]    written_value;
    logic               mem_stored;
    logic [Xlen-1:0]    mem_address;
  } retire_t;

  logic clk_i;
  logic rst_ni;

  rv32ex_in_if  instr_if ();
  rv32ex_out_if retire_if ();

  rv32i_execute_unit dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (instr_if),
    .out_o  (retire_if)
  );

  // Architectural state held by the bench
  logic [Xlen-1:0] arch_reg [NumRegs];
  logic [Xlen-1:0] arch_pc;
  logic [7:0]      data_mem [MemBytes];
  bit              mem_written [MemBytes];
  logic [AddrW-1:0] hot_addr [HotAddrs];

  retire_t     pending_retire [$];
  int unsigned error_count;
  int unsigned retire_count;

  // Traffic shaping: when set, the side runs without any idle cycles
  bit steady_in;
  bit steady_out;

  // --------------------------------------------------------------------------
  // Clock and the overall time limit
  // --------------------------------------------------------------------------
  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    #20_000_000;
    $display("TB_ERROR");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Bench model of the execute unit
  // --------------------------------------------------------------------------
  function automatic logic [Xlen-1:0] load_le(logic [Xlen-1:0] addr, int unsigned n);
    logic [Xlen-1:0]  v;
    logic [AddrW-1:0] ix;
    v = '0;
    for (int unsigned i = 0; i < n; i++) begin
      ix = addr[AddrW-1:0] + AddrW'(i);
      v  = v | (Xlen'(data_mem[ix]) << (8 * i));
    end
    return v;
  endfunction

  function automatic void store_le(logic [Xlen-1:0] addr, logic [Xlen-1:0] v,
                                   int unsigned n);
    logic [AddrW-1:0] ix;
    for (int unsigned i = 0; i < n; i++) begin
      ix              = addr[AddrW-1:0] + AddrW'(i);
      data_mem[ix]    = v[8*i +: 8];
      mem_written[ix] = 1'b1;
    end
  endfunction

  // Execute one instruction on the bench state and return what must retire
  function automatic retire_t execute_instr(logic [OpW-1:0] op, logic [RegIdxW-1:0] rd,
                                            logic [RegIdxW-1:0] rs1,
                                            logic [RegIdxW-1:0] rs2,
                                            logic [ImmW-1:0] imm21);
    retire_t         r;
    logic [Xlen-1:0] a, b, imm, upper, npc, addr, val;
    logic            wr, st, taken;
    a     = arch_reg[rs1];
    b     = arch_reg[rs2];
    imm   = {{(Xlen-ImmW){imm21[ImmW-1]}}, imm21};
    upper = {imm21[19:0], 12'h000};
    npc   = arch_pc + 32'd4;
    addr  = a + imm;
    val   = '0;
    wr    = 1'b0;
    st    = 1'b0;
    taken = 1'b0;
    r     = '0;
    case (op)
      OP_LUI:   begin val = upper;           wr = 1'b1; end
      OP_AUIPC: begin val = upper + arch_pc; wr = 1'b1; end
      OP_JAL: begin
        val = arch_pc + 32'd4;
        npc = arch_pc + imm;
        wr  = 1'b1;
      end
      OP_JALR: begin
        // target comes from the old rs1, even when rd is the same register
        val = arch_pc + 32'd4;
        npc = (a + imm) & JalrMask;
        wr  = 1'b1;
      end
      OP_BEQ:  taken = (a == b);
      OP_BNE:  taken = (a != b);
      OP_BLT:  taken = ($signed(a) <  $signed(b));
      OP_BGE:  taken = ($signed(a) >= $signed(b));
      OP_BLTU: taken = (a <  b);
      OP_BGEU: taken = (a >= b);
      OP_LB: begin
        val = load_le(addr, 1);
        val = {{24{val[7]}}, val[7:0]};
        wr  = 1'b1;
        r.mem_address = addr;
      end
      OP_LH: begin
        val = load_le(addr, 2);
        val = {{16{val[15]}}, val[15:0]};
        wr  = 1'b1;
        r.mem_address = addr;
      end
      OP_LW:  begin val = load_le(addr, 4); wr = 1'b1; r.mem_address = addr; end
      OP_LBU: begin val = load_le(addr, 1); wr = 1'b1; r.mem_address = addr; end
      OP_LHU: begin val = load_le(addr, 2); wr = 1'b1; r.mem_address = addr; end
      OP_SB:  begin store_le(addr, b, 1); st = 1'b1; r.mem_address = addr; end
      OP_SH:  begin store_le(addr, b, 2); st = 1'b1; r.mem_address = addr; end
      OP_SW:  begin store_le(addr, b, 4); st = 1'b1; r.mem_address = addr; end
      OP_ADDI:  begin val = a + imm;                              wr = 1'b1; end
      OP_SLTI:  begin val = Xlen'($signed(a) < $signed(imm));     wr = 1'b1; end
      OP_SLTIU: begin val = Xlen'(a < imm);                       wr = 1'b1; end
      OP_XORI:  begin val = a ^ imm;                              wr = 1'b1; end
      OP_ORI:   begin val = a | imm;                              wr = 1'b1; end
      OP_ANDI:  begin val = a & imm;                              wr = 1'b1; end
      OP_SLLI:  begin val = a << imm[ShamtW-1:0];                 wr = 1'b1; end
      OP_SRLI:  begin val = a >> imm[ShamtW-1:0];                 wr = 1'b1; end
      OP_SRAI:  begin val = $signed(a) >>> imm[ShamtW-1:0];       wr = 1'b1; end
      OP_ADD:   begin val = a + b;                                wr = 1'b1; end
      OP_SUB:   begin val = a - b;                                wr = 1'b1; end
      OP_SLL:   begin val = a << b[ShamtW-1:0];                   wr = 1'b1; end
      OP_SLT:   begin val = Xlen'($signed(a) < $signed(b));       wr = 1'b1; end
      OP_SLTU:  begin val = Xlen'(a < b);                         wr = 1'b1; end
      OP_XOR:   begin val = a ^ b;                                wr = 1'b1; end
      OP_SRL:   begin val = a >> b[ShamtW-1:0];                   wr = 1'b1; end
      OP_SRA:   begin val = $signed(a) >>> b[ShamtW-1:0];         wr = 1'b1; end
      OP_OR:    begin val = a | b;                                wr = 1'b1; end
      OP_AND:   begin val = a & b;                                wr = 1'b1; end
      default: ;
    endcase
    if (taken) npc = arch_pc + imm;
    // drop writes to x0 so that it keeps reading zero
    if (wr && rd != '0) begin
      arch_reg[rd]    = val;
      r.reg_written   = 1'b1;
      r.written_index = rd;
      r.written_value = val;
    end
    arch_pc      = npc;
    r.next_pc    = npc;
    r.mem_stored = st;
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  // Idle length: mostly none or short, now and then a long pause
  function automatic int unsigned idle_len(int unsigned pct_none);
    if ($urandom_range(0, 99) < pct_none) return 0;
    if ($urandom_range(0, 9) < 8) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Immediate that makes base + imm land on the memory address tgt; the bits
  // above the memory window are random so the full-width address varies
  function automatic logic [ImmW-1:0] imm_for(logic [Xlen-1:0] base,
                                              logic [AddrW-1:0] tgt);
    logic [ImmW-1:0] r;
    r            = ImmW'($urandom);
    r[AddrW-1:0] = tgt - base[AddrW-1:0];
    return r;
  endfunction

  function automatic logic [ImmW-1:0] random_imm();
    case ($urandom_range(0, 6))
      0, 1, 2: return ImmW'($urandom);
      3:       return ImmW'($urandom_range(0, 63)) - ImmW'(32);
      4:       return ImmW'($urandom_range(0, 63));
      5: begin
        case ($urandom_range(0, 4))
          0:       return ImmMax;
          1:       return ImmMin;
          2:       return ImmAll;
          3:       return '0;
          default: return ImmW'(1);
        endcase
      end
      default: return ImmW'($urandom_range(0, 4095)) - ImmW'(2048);
    endcase
  endfunction

  function automatic logic [AddrW-1:0] pick_addr();
    if ($urandom_range(0, 3) != 0) return hot_addr[$urandom_range(0, HotAddrs - 1)];
    return AddrW'($urandom);
  endfunction

  function automatic bit bytes_written(logic [AddrW-1:0] tgt, int unsigned n);
    logic [AddrW-1:0] ix;
    for (int unsigned i = 0; i < n; i++) begin
      ix = tgt + AddrW'(i);
      if (!mem_written[ix]) return 1'b0;
    end
    return 1'b1;
  endfunction

  task automatic report_mismatch(input string what);
    $display("[%0t] mismatch: %s", $realtime, what);
    error_count++;
  endtask

  // Send one instruction, hold it until accepted, then record its outcome
  task automatic send_instr(input logic [OpW-1:0] op, input logic [RegIdxW-1:0] rd,
                            input logic [RegIdxW-1:0] rs1,
                            input logic [RegIdxW-1:0] rs2,
                            input logic [ImmW-1:0] imm);
    int unsigned gap;
    retire_t     outcome;
    gap = steady_in ? 0 : idle_len(55);
    if (gap != 0) begin
      instr_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    instr_if.valid         <= 1'b1;
    instr_if.opcode        <= op;
    instr_if.dest_index    <= rd;
    instr_if.source1_index <= rs1;
    instr_if.source2_index <= rs2;
    instr_if.immediate     <= imm;
    do @(posedge clk_i); while (!instr_if.ready);
    outcome = execute_instr(op, rd, rs1, rs2, imm);
    pending_retire.insert(pending_retire.size(), outcome);
  endtask

  // Send a memory instruction at address tgt via base register rs1
  task automatic send_mem(input logic [OpW-1:0] op, input logic [RegIdxW-1:0] rd,
                          input logic [RegIdxW-1:0] rs1,
                          input logic [RegIdxW-1:0] rs2,
                          input logic [AddrW-1:0] tgt);
    send_instr(op, rd, rs1, rs2, imm_for(arch_reg[rs1], tgt));
  endtask

  // Build a random instruction of the given opcode; before a load,
  // write its bytes first if any of them has never been stored
  task automatic issue_random(input logic [OpW-1:0] op);
    logic [RegIdxW-1:0] rd, rs1, rs2, base;
    logic [AddrW-1:0]   tgt;
    int unsigned        n;
    rd  = RegIdxW'($urandom);
    rs1 = RegIdxW'($urandom);
    rs2 = ($urandom_range(0, 4) == 0) ? rs1 : RegIdxW'($urandom);
    if (op >= OP_LB && op <= OP_SW) begin
      tgt = pick_addr();
      if (op <= OP_LHU) begin
        n = (op == OP_LW) ? 4 : ((op == OP_LH || op == OP_LHU) ? 2 : 1);
        if (!bytes_written(tgt, n)) begin
          base = RegIdxW'($urandom);
          send_mem(OP_SW, RegIdxW'($urandom), base, RegIdxW'($urandom), tgt);
        end
      end
      send_mem(op, rd, rs1, rs2, tgt);
    end else begin
      send_instr(op, rd, rs1, rs2, random_imm());
    end
  endtask

  task automatic wait_for_drain();
    int unsigned guard;
    guard = 0;
    while (pending_retire.size() != 0 && guard < DrainLimit) begin
      @(posedge clk_i);
      guard++;
    end
    if (pending_retire.size() != 0)
      report_mismatch($sformatf("%0d results never retired", pending_retire.size()));
    repeat (TailCycles) @(posedge clk_i);
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------
  // Load operand registers with sign and magnitude extremes
  task automatic test_operand_setup();
    send_instr(OP_LUI,  5'd1, 5'd0, 5'd0, 21'h08_0000);  // 0x8000_0000
    send_instr(OP_LUI,  5'd2, 5'd0, 5'd0, 21'h08_0000);
    send_instr(OP_ADDI, 5'd2, 5'd2, 5'd0, ImmAll);       // 0x7FFF_FFFF
    send_instr(OP_ADDI, 5'd3, 5'd0, 5'd0, ImmAll);       // 0xFFFF_FFFF
    send_instr(OP_ADDI, 5'd4, 5'd0, 5'd0, -21'sd27);     // low five bits 5
  endtask

  // One of each operation, with extreme operands and immediates
  task automatic test_all_operations();
    send_instr(OP_LUI,   5'd5, 5'd0, 5'd0, ImmAll);
    send_instr(OP_AUIPC, 5'd6, 5'd0, 5'd0, ImmMax);
    send_instr(OP_JAL,   5'd7, 5'd0, 5'd0, ImmMin);
    send_instr(OP_JALR,  5'd8, 5'd3, 5'd0, '0);
    send_instr(OP_BEQ,   5'd0, 5'd1, 5'd1, ImmMax);
    send_instr(OP_BNE,   5'd0, 5'd1, 5'd1, -21'sd4);
    send_instr(OP_BLT,   5'd0, 5'd1, 5'd2, 21'd8);
    send_instr(OP_BGE,   5'd0, 5'd2, 5'd1, -21'sd8);
    send_instr(OP_BLTU,  5'd0, 5'd1, 5'd2, 21'd12);
    send_instr(OP_BGEU,  5'd0, 5'd3, 5'd1, 21'd16);
    // word straddling the top of memory: bytes wrap round to address zero
    send_mem(OP_SW,  5'd0,  5'd2,  5'd1, 16'hFFFD);
    send_mem(OP_LB,  5'd9,  5'd1,  5'd0, 16'h0000);
    send_mem(OP_LH,  5'd10, 5'd3,  5'd0, 16'hFFFF);
    send_mem(OP_LW,  5'd11, 5'd4,  5'd0, 16'hFFFD);
    send_mem(OP_LBU, 5'd12, 5'd0,  5'd0, 16'h0000);
    send_mem(OP_LHU, 5'd13, 5'd2,  5'd0, 16'hFFFF);
    send_mem(OP_SB,  5'd0,  5'd31, 5'd3, 16'h0010);
    send_mem(OP_SH,  5'd0,  5'd1,  5'd2, 16'hFFFF);
    send_instr(OP_ADDI,  5'd14, 5'd2, 5'd0, 21'd1);
    send_instr(OP_SLTI,  5'd15, 5'd1, 5'd0, '0);
    send_instr(OP_SLTIU, 5'd16, 5'd1, 5'd0, ImmAll);
    send_instr(OP_XORI,  5'd17, 5'd3, 5'd0, ImmMax);
    send_instr(OP_ORI,   5'd18, 5'd0, 5'd0, ImmMin);
    send_instr(OP_ANDI,  5'd19, 5'd3, 5'd0, 21'h15_5555);
    send_instr(OP_SLLI,  5'd20, 5'd3, 5'd0, ImmAll);     // upper immediate bits ignored
    send_instr(OP_SRLI,  5'd21, 5'd1, 5'd0, 21'h00_001F);
    send_instr(OP_SRAI,  5'd22, 5'd1, 5'd0, 21'h00_003F);
    send_instr(OP_ADD,   5'd23, 5'd2, 5'd2, '0);
    send_instr(OP_SUB,   5'd24, 5'd1, 5'd3, '0);
    send_instr(OP_SLL,   5'd25, 5'd3, 5'd4, '0);         // shift by low bits of rs2
    send_instr(OP_SLT,   5'd26, 5'd1, 5'd2, '0);
    send_instr(OP_SLTU,  5'd27, 5'd1, 5'd2, '0);
    send_instr(OP_XOR,   5'd28, 5'd1, 5'd3, '0);
    send_instr(OP_SRL,   5'd29, 5'd1, 5'd4, '0);
    send_instr(OP_SRA,   5'd30, 5'd1, 5'd4, '0);
    send_instr(OP_OR,    5'd31, 5'd1, 5'd2, '0);
    send_instr(OP_AND,   5'd5,  5'd3, 5'd4, '0);
  endtask

  // Unknown opcodes, writes to x0 and a jump whose rd is its own base
  task automatic test_special_cases();
    send_instr(OpUnknownLo, 5'd31, 5'd31, 5'd31, ImmAll);
    send_instr(OpUnknownHi, 5'd9,  5'd3,  5'd1,  ImmMin);
    send_instr(OP_ADDI,     5'd0,  5'd3,  5'd0,  21'd5);
    send_instr(OP_ADD,      5'd9,  5'd0,  5'd0,  '0);
    send_instr(OP_JALR,     5'd3,  5'd3,  5'd0,  21'd3);
    send_instr(OP_JAL,      5'd0,  5'd0,  5'd0,  21'd2);
  endtask

  // Long random stream; idling style changes every block of items
  task automatic test_random_stream(input int unsigned n_items);
    logic [OpW-1:0] op;
    for (int unsigned i = 0; i < n_items; i++) begin
      if (i % 80 == 0) begin
        steady_in  = ($urandom_range(0, 3) == 0);
        steady_out = ($urandom_range(0, 3) == 0);
      end
      if ($urandom_range(0, 19) == 0) op = OpW'($urandom_range(OpUnknownLo, OpUnknownHi));
      else op = OpW'($urandom_range(OP_LUI, OP_AND));
      issue_random(op);
    end
    steady_in  = 1'b0;
    steady_out = 1'b0;
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    rst_ni       = 1'b0;
    error_count  = 0;
    retire_count = 0;
    steady_in    = 1'b0;
    steady_out   = 1'b0;
    arch_pc      = '0;
    for (int i = 0; i < NumRegs; i++) arch_reg[i] = '0;
    for (int i = 0; i < MemBytes; i++) mem_written[i] = 1'b0;
    // hot addresses: the wrap corner, a small window that overlaps a lot,
    // and a few scattered spots
    for (int i = 0; i < HotAddrs; i++) begin
      if (i < 4)       hot_addr[i] = AddrW'(MemBytes - 4 + i);
      else if (i < 16) hot_addr[i] = AddrW'(16'h0400 + $urandom_range(0, 31));
      else             hot_addr[i] = AddrW'($urandom);
    end
    instr_if.valid         <= 1'b0;
    instr_if.opcode        <= '0;
    instr_if.dest_index    <= '0;
    instr_if.source1_index <= '0;
    instr_if.source2_index <= '0;
    instr_if.immediate     <= '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_operand_setup();
    test_all_operations();
    test_special_cases();
    test_random_stream(RandomItems);

    instr_if.valid <= 1'b0;
    wait_for_drain();
    if (error_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // --------------------------------------------------------------------------
  // Result side: random back-pressure
  // --------------------------------------------------------------------------
  initial begin
    int unsigned stall_left;
    stall_left = 0;
    retire_if.ready <= 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      @(posedge clk_i);
      if (stall_left != 0 && !steady_out) begin
        retire_if.ready <= 1'b0;
        stall_left--;
      end else begin
        retire_if.ready <= 1'b1;
        stall_left = 0;
        if (!steady_out && $urandom_range(0, 99) < 15) stall_left = idle_len(0);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Result checking: compare each retired item with the oldest outcome
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin : retire_check
    retire_t want;
    if (rst_ni && retire_if.valid && retire_if.ready) begin
      retire_count++;
      if (pending_retire.size() == 0) begin
        report_mismatch($sformatf("result %0d retired with nothing outstanding",
                                  retire_count));
      end else begin
        want = pending_retire.pop_front();
        if (retire_if.next_pc !== want.next_pc)
          report_mismatch($sformatf("result %0d next_pc %h, want %h", retire_count,
                                    retire_if.next_pc, want.next_pc));
        if (retire_if.reg_written !== want.reg_written)
          report_mismatch($sformatf("result %0d reg_written %b, want %b", retire_count,
                                    retire_if.reg_written, want.reg_written));
        if (retire_if.written_index !== want.written_index)
          report_mismatch($sformatf("result %0d written_index %0d, want %0d",
                                    retire_count, retire_if.written_index,
                                    want.written_index));
        if (retire_if.written_value !== want.written_value)
          report_mismatch($sformatf("result %0d written_value %h, want %h",
                                    retire_count, retire_if.written_value,
                                    want.written_value));
        if (retire_if.mem_stored !== want.mem_stored)
          report_mismatch($sformatf("result %0d mem_stored %b, want %b", retire_count,
                                    retire_if.mem_stored, want.mem_stored));
        if (retire_if.mem_address !== want.mem_address)
          report_mismatch($sformatf("result %0d mem_address %h, want %h", retire_count,
                                    retire_if.mem_address, want.mem_address));
      end
    end
  end

endmodule
